// ===== hdl/stxbcc_pkg.sv =====
// stxbcc_pkg: shared types, constants and the status builder for the
// stx/etx frame checker; no dependencies
package stxbcc_pkg;

    localparam int STX_MAX_FRAME = 128;
    localparam int HDR_BYTES     = 14;
    localparam int DATA_OFFSET   = 15;

    localparam logic [7:0] START_RESET = 8'hA0;
    localparam logic [7:0] END_RESET   = 8'h05;

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_BCC   = 3'd3;
    localparam logic [2:0] ST_BAD_END   = 3'd4;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_out;
        logic [2:0]  status;
        logic [7:0]  condition_bits;
        logic [15:0] frame_number;
        logic [15:0] source_id;
        logic [15:0] destination_id;
        logic [7:0]  command;
        logic [7:0]  error_flag;
        logic [31:0] extra_data;
        logic [6:0]  data_length;
    } t_out;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } t_cfg;

    typedef struct packed {
        logic valid;
        t_out item;
    } t_res;

    function automatic t_out make_status(input t_hdr hdr, input logic [2:0] st);
        t_out o;
        o.kind           = KIND_STATUS;
        o.data_out       = 8'd0;
        o.status         = st;
        o.condition_bits = hdr[0];
        o.frame_number   = {hdr[2], hdr[1]};
        o.source_id      = {hdr[4], hdr[3]};
        o.destination_id = {hdr[6], hdr[5]};
        o.command        = hdr[7];
        o.error_flag     = hdr[8];
        o.extra_data     = {hdr[12], hdr[11], hdr[10], hdr[9]};
        o.data_length    = hdr[13][6:0];
        return o;
    endfunction

endpackage

// ===== hdl/stx_etx_bcc_frame_checker_core.sv =====
// stx_etx_bcc_frame_checker_core: receive-side stx/etx frame checker, top level
// a result is registered and visible in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; the byte path is a compare and an xor into the
//   result register, which takes a new byte whenever it is empty or being drained
// reset (i_rst_n, synchronous): no frame open, header and xor cleared, markers 0xA0/0x05
// depends on stxbcc_pkg, stxbcc_parser
module stx_etx_bcc_frame_checker_core #(
    parameter int MAX_FRAME = stxbcc_pkg::STX_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stxbcc_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output stxbcc_pkg::t_out  o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    stxbcc_pkg::t_cfg  r_cfg;
    stxbcc_pkg::t_res  res;
    logic              r_out_valid;
    stxbcc_pkg::t_out  r_out_data;
    logic              take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign take        = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= stxbcc_pkg::START_RESET;
            r_cfg.end_marker   <= stxbcc_pkg::END_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stxbcc_pkg::CFG_START: r_cfg.start_marker <= i_cfg_data;
                stxbcc_pkg::CFG_END:   r_cfg.end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stxbcc_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_item  (i_in_data),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out_data <= res.item;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= stxbcc_pkg::ST_BAD_END)
        else $error("status code out of range");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == stxbcc_pkg::KIND_DATA) |->
        (o_out_data.status == stxbcc_pkg::ST_OK && o_out_data.data_length == 7'd0 &&
         o_out_data.extra_data == 32'd0))
        else $error("payload result carries header fields");

    a_bad_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == stxbcc_pkg::KIND_STATUS &&
         o_out_data.status == stxbcc_pkg::ST_BAD_START) |->
        (o_out_data.condition_bits == 8'd0 && o_out_data.frame_number == 16'd0 &&
         o_out_data.data_length == 7'd0))
        else $error("bad start status with stale header");

    a_new_result_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !res.valid) |=> !o_out_valid)
        else $error("result shown for a byte that makes none");

endmodule

// ===== hdl/stxbcc_parser.sv =====
// stxbcc_parser: frame position tracking, header capture and bcc check
// depends on stxbcc_pkg
module stxbcc_parser #(
    parameter int MAX_FRAME = stxbcc_pkg::STX_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stxbcc_pkg::t_cfg  i_cfg,
    input  logic              i_take,
    input  stxbcc_pkg::t_in   i_item,
    output stxbcc_pkg::t_res  o_res
);

    localparam int PosW     = $clog2(MAX_FRAME);
    localparam int LenLimit = MAX_FRAME - 17;

    logic [PosW-1:0]       r_pos, n_pos;
    logic                  r_active, n_active;
    logic [7:0]            r_xor, n_xor;
    stxbcc_pkg::t_hdr      r_hdr, n_hdr;

    logic [7:0]            b;
    logic [3:0]            hdr_idx;
    logic [8:0]            pos_ext;
    logic [8:0]            data_end;

    assign b        = i_item.in_byte;
    assign hdr_idx  = 4'(r_pos - PosW'(1));
    assign pos_ext  = 9'(r_pos);
    assign data_end = 9'(stxbcc_pkg::DATA_OFFSET) + {1'b0, r_hdr[stxbcc_pkg::HDR_BYTES-1]};

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        n_xor    = r_xor;
        n_hdr    = r_hdr;
        o_res    = '0;
        if (i_take) begin
            if (i_item.first_byte) begin
                n_hdr = '0;
                n_xor = 8'd0;
                n_pos = PosW'(1);
                if (b != i_cfg.start_marker) begin
                    n_active   = 1'b0;
                    o_res.valid = 1'b1;
                    o_res.item  = stxbcc_pkg::make_status('0, stxbcc_pkg::ST_BAD_START);
                end else begin
                    n_active = 1'b1;
                end
            end else if (r_active) begin
                n_xor = r_xor ^ b;
                if (r_pos <= PosW'(stxbcc_pkg::HDR_BYTES)) begin
                    n_hdr[hdr_idx] = b;
                    if (r_pos == PosW'(stxbcc_pkg::HDR_BYTES) && b > 8'(LenLimit)) begin
                        n_active    = 1'b0;
                        o_res.valid = 1'b1;
                        o_res.item  = stxbcc_pkg::make_status(n_hdr, stxbcc_pkg::ST_BAD_LEN);
                    end else begin
                        n_pos = r_pos + PosW'(1);
                    end
                end else if (pos_ext < data_end) begin
                    n_pos               = r_pos + PosW'(1);
                    o_res.valid         = 1'b1;
                    o_res.item.kind     = stxbcc_pkg::KIND_DATA;
                    o_res.item.data_out = b;
                end else if (pos_ext == data_end) begin
                    // bcc byte
                    n_pos = r_pos + PosW'(1);
                end else begin
                    // end byte, keep xor over header, data and bcc only
                    n_xor       = r_xor;
                    n_active    = 1'b0;
                    o_res.valid = 1'b1;
                    if (b != i_cfg.end_marker) begin
                        o_res.item = stxbcc_pkg::make_status(r_hdr, stxbcc_pkg::ST_BAD_END);
                    end else if (r_xor != 8'd0) begin
                        o_res.item = stxbcc_pkg::make_status(r_hdr, stxbcc_pkg::ST_BAD_BCC);
                    end else begin
                        o_res.item = stxbcc_pkg::make_status(r_hdr, stxbcc_pkg::ST_OK);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_active <= 1'b0;
            r_xor    <= 8'd0;
            r_hdr    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_active <= n_active;
            r_xor    <= n_xor;
            r_hdr    <= n_hdr;
        end
    end

endmodule

// ===== sim/stx_etx_bcc_frame_checker_core_tb.sv =====
// stx_etx_bcc_frame_checker_core_tb: self-checking bench for the stx/etx frame checker,
// random framed byte streams against an in-bench frame tracker over several marker settings
// depends on stxbcc_pkg and stx_etx_bcc_frame_checker_core
module stx_etx_bcc_frame_checker_core_tb;
    import stxbcc_pkg::*;

    typedef enum int {
        FLAW_NONE, FLAW_START, FLAW_LEN, FLAW_BCC, FLAW_END, FLAW_BOTH, FLAW_CUT
    } flaw_e;

    localparam int MAX_PAYLOAD = STX_MAX_FRAME - 17;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in        i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_START;
    logic [7:0] i_cfg_data = 8'd0;

    t_in  rx_bytes_pending[$];
    t_out frame_results_due[$];

    int bytes_queued = 0;
    int bytes_offered = 0;
    int bytes_taken = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int data_seen = 0;
    int status_seen[5] = '{default: 0};

    // frame tracker state
    logic [7:0] start_mark = START_RESET;
    logic [7:0] end_mark = END_RESET;
    logic       frame_open = 1'b0;
    int         frame_pos = 0;
    logic [7:0] frame_xor = 8'd0;
    t_hdr       hdr_bytes = '0;

    stx_etx_bcc_frame_checker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2400000;
        $display("stx_etx_bcc_frame_checker_core_tb: FAIL");
        $finish;
    end

    function automatic t_out frame_status(input logic [2:0] st);
        t_out o;
        o                = '0;
        o.kind           = KIND_STATUS;
        o.status         = st;
        o.condition_bits = hdr_bytes[0];
        o.frame_number   = {hdr_bytes[2], hdr_bytes[1]};
        o.source_id      = {hdr_bytes[4], hdr_bytes[3]};
        o.destination_id = {hdr_bytes[6], hdr_bytes[5]};
        o.command        = hdr_bytes[7];
        o.error_flag     = hdr_bytes[8];
        o.extra_data     = {hdr_bytes[12], hdr_bytes[11], hdr_bytes[10], hdr_bytes[9]};
        o.data_length    = hdr_bytes[13][6:0];
        return o;
    endfunction

    function automatic void advance_frame(input t_in it);
        logic [7:0] b;
        t_out       d;
        b = it.in_byte;
        if (it.first_byte) begin
            hdr_bytes = '0;
            frame_xor = 8'd0;
            frame_pos = 1;
            frame_open = (b == start_mark);
            if (!frame_open) begin
                frame_results_due.push_back(frame_status(ST_BAD_START));
            end
        end else if (frame_open) begin
            frame_xor = frame_xor ^ b;
            if (frame_pos <= HDR_BYTES) begin
                hdr_bytes[frame_pos - 1] = b;
                if (frame_pos == HDR_BYTES && int'(b) + 17 > STX_MAX_FRAME) begin
                    frame_open = 1'b0;
                    frame_results_due.push_back(frame_status(ST_BAD_LEN));
                end else begin
                    frame_pos++;
                end
            end else if (frame_pos < DATA_OFFSET + int'(hdr_bytes[HDR_BYTES - 1])) begin
                frame_pos++;
                d = '0;
                d.kind = KIND_DATA;
                d.data_out = b;
                frame_results_due.push_back(d);
            end else if (frame_pos == DATA_OFFSET + int'(hdr_bytes[HDR_BYTES - 1])) begin
                frame_pos++;
            end else begin
                // end byte was folded into the xor, take it back out
                frame_xor = frame_xor ^ b;
                frame_open = 1'b0;
                if (b != end_mark) begin
                    frame_results_due.push_back(frame_status(ST_BAD_END));
                end else if (frame_xor != 8'd0) begin
                    frame_results_due.push_back(frame_status(ST_BAD_BCC));
                end else begin
                    frame_results_due.push_back(frame_status(ST_OK));
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && bytes_taken != bytes_offered)) begin
            if (rx_bytes_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data <= rx_bytes_pending.pop_front();
                i_in_valid <= 1'b1;
                bytes_offered <= bytes_offered + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            i_out_stall <= 1'b1;
            hold_seen <= hold_seen + 1;
            hold_left <= 200;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (o_out_data.kind == KIND_DATA) begin
                    data_seen++;
                end else if (o_out_data.status <= ST_BAD_END) begin
                    status_seen[o_out_data.status]++;
                end
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             o_out_data);
                    errors++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("kind", want.kind, o_out_data.kind);
                    check_field("data_out", want.data_out, o_out_data.data_out);
                    check_field("status", want.status, o_out_data.status);
                    check_field("condition_bits", want.condition_bits,
                                o_out_data.condition_bits);
                    check_field("frame_number", want.frame_number, o_out_data.frame_number);
                    check_field("source_id", want.source_id, o_out_data.source_id);
                    check_field("destination_id", want.destination_id,
                                o_out_data.destination_id);
                    check_field("command", want.command, o_out_data.command);
                    check_field("error_flag", want.error_flag, o_out_data.error_flag);
                    check_field("extra_data", want.extra_data, o_out_data.extra_data);
                    check_field("data_length", want.data_length, o_out_data.data_length);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                advance_frame(i_in_data);
                bytes_taken <= bytes_taken + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START) begin
                    start_mark <= i_cfg_data;
                end else begin
                    end_mark <= i_cfg_data;
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] v, input logic first);
        t_in it;
        it.in_byte = v;
        it.first_byte = first;
        rx_bytes_pending.push_back(it);
        bytes_queued++;
    endtask

    task automatic queue_frame(input int len, input flaw_e flaw);
        logic [7:0] fb[$];
        logic [7:0] bcc;
        logic [7:0] v;
        int         count;
        bcc = 8'd0;
        fb.push_back(flaw == FLAW_START ? start_mark ^ 8'($urandom_range(1, 255)) : start_mark);
        for (int i = 1; i < HDR_BYTES; i++) begin
            v = 8'($urandom_range(255));
            fb.push_back(v);
            bcc ^= v;
        end
        v = (flaw == FLAW_LEN) ? 8'($urandom_range(MAX_PAYLOAD + 1, 255)) : 8'(len);
        fb.push_back(v);
        bcc ^= v;
        for (int i = 0; i < len; i++) begin
            v = 8'($urandom_range(255));
            fb.push_back(v);
            bcc ^= v;
        end
        if (flaw == FLAW_BCC || flaw == FLAW_BOTH) begin
            bcc ^= 8'($urandom_range(1, 255));
        end
        fb.push_back(bcc);
        if (flaw == FLAW_END || flaw == FLAW_BOTH) begin
            fb.push_back(end_mark ^ 8'($urandom_range(1, 255)));
        end else begin
            fb.push_back(end_mark);
        end
        case (flaw)
            FLAW_START: begin
                count = 1 + $urandom_range(3);
            end
            FLAW_LEN: begin
                count = 15 + $urandom_range(3);
            end
            FLAW_CUT: begin
                count = $urandom_range(1, fb.size() - 1);
            end
            default: begin
                count = fb.size();
            end
        endcase
        for (int i = 0; i < count; i++) begin
            push_byte(fb[i], i == 0);
        end
    endtask

    task automatic random_frames(input int target);
        int    stop_at;
        int    r;
        int    len;
        flaw_e flaw;
        stop_at = bytes_queued + target;
        while (bytes_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 58) begin
                flaw = FLAW_NONE;
            end else if (r < 66) begin
                flaw = FLAW_BCC;
            end else if (r < 74) begin
                flaw = FLAW_END;
            end else if (r < 78) begin
                flaw = FLAW_BOTH;
            end else if (r < 84) begin
                flaw = FLAW_START;
            end else if (r < 90) begin
                flaw = FLAW_LEN;
            end else begin
                flaw = FLAW_CUT;
            end
            if ($urandom_range(99) < 3) begin
                len = MAX_PAYLOAD - $urandom_range(2);
            end else begin
                len = $urandom_range(12);
            end
            queue_frame(len, flaw);
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    task automatic settle();
        while (rx_bytes_pending.size() > 0 || bytes_taken != bytes_offered ||
               frame_results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset markers, light sender gaps, heavy receiver stalls
        send_idle_pct = 33;
        recv_idle_pct = 88;
        push_byte(8'h00, 1'b0);
        push_byte(start_mark ^ 8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(start_mark, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b0);
        queue_frame(0, FLAW_LEN);
        random_frames(370);
        settle();

        write_reg(CFG_START, 8'h00);
        write_reg(CFG_END, 8'hFF);
        send_idle_pct = 88;
        recv_idle_pct = 33;
        random_frames(390);
        settle();

        write_reg(CFG_START, 8'hFF);
        write_reg(CFG_END, 8'h00);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks = 1;
        random_frames(390);
        settle();

        write_reg(CFG_START, 8'($urandom_range(255)));
        write_reg(CFG_END, 8'($urandom_range(255)));
        random_frames(370);
        settle();

        if (frame_results_due.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     frame_results_due.size());
            errors++;
        end
        $display("ran %0d bytes over four marker settings, %0d payload bytes passed out",
                 bytes_taken, data_seen);
        $display("statuses ok %0d, bad start %0d, bad length %0d, bad bcc %0d, bad end %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0) begin
            $display("stx_etx_bcc_frame_checker_core_tb: PASS");
        end else begin
            $display("stx_etx_bcc_frame_checker_core_tb: FAIL");
        end
        $finish;
    end

endmodule
